[src/de_bruijn_greedy_generator_top_assert.svh]
// ----------------------------------------------------------------------------
// de Bruijn generator assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef DE_BRUIJN_GREEDY_GENERATOR_TOP_ASSERT_SVH
`define DE_BRUIJN_GREEDY_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DBGG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define DBGG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/dbgg_pkg.sv]
// ----------------------------------------------------------------------------
// dbgg_pkg
// Shared codes and widths of the de Bruijn sequence generator.
// ----------------------------------------------------------------------------
package dbgg_pkg;

  localparam int CFG_W   = 4;
  localparam int TDATA_W = 8;
  localparam int DIGIT_W = 4;
  localparam int EPOCH_W = 4;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_FIN = 2'd1;
  localparam status_t ST_ERR = 2'd2;

  localparam logic REG_ORDER   = 1'b0;
  localparam logic REG_SYMBOLS = 1'b1;

endpackage

[src/de_bruijn_greedy_generator_top.sv]
// ----------------------------------------------------------------------------
// de_bruijn_greedy_generator_top
// Prefer-largest greedy de Bruijn sequence generator over a seen-word RAM.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side is one request: s_tdata[0] = 1 restarts the
// sequence and returns its first digit, 0 asks for the next digit. Each
// request gives exactly one transfer on the m_ side: m_tdata holds the digit,
// m_tuser the status (ok, finished, size error), m_tlast flags the digit that
// covers the final word. order and symbols are set through cfg_we/cfg_addr/
// cfg_data; the user must write them only while no request is in flight,
// the block itself does not enforce this.
// A digit request first takes the bit-serial remainder of the window by
// symbols^(order-1), then makes one RAM read per candidate digit, pipelined
// over the single read port. The first request after a register write
// rebuilds symbols^order by repeated multiplication.
// Seen words are stamped with an epoch in the RAM; restart bumps the epoch.
// After reset, and on every fifteenth restart, a clearing pass writes all
// STORE_WORDS entries, one per cycle, and s_tready stays low meanwhile.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds m_* and stops the engine at its last step.
// ----------------------------------------------------------------------------
module de_bruijn_greedy_generator_top #(
  parameter int MAX_ORDER   = 12,
  parameter int MAX_SYMBOLS = 10,
  parameter int STORE_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [dbgg_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dbgg_pkg::TDATA_W-1:0]  s_tdata,   // [0] restart
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dbgg_pkg::TDATA_W-1:0]  m_tdata,   // [3:0] digit
  output logic                          m_tlast,
  output dbgg_pkg::status_t             m_tuser    // [1:0] status
);

  import dbgg_pkg::*;

  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int P_W    = $clog2(STORE_WORDS + 2);
  localparam int W_W    = $clog2(STORE_WORDS + 1);
  localparam int CNT_W  = $clog2(ADDR_W + 1);
  localparam int M_W    = P_W + CFG_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_POW, S_EVAL, S_PRE, S_MOD, S_MUL, S_SEARCH, S_DONE
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      order;
  logic [CFG_W-1:0]      symbols;
  logic                  dirty;
  logic                  pend;
  logic [ADDR_W-1:0]     clr_addr;
  logic [EPOCH_W-1:0]    cur_ep;
  logic [P_W-1:0]        p;
  logic [P_W-1:0]        high;
  logic                  sat;
  logic [CFG_W-1:0]      pcnt;
  logic [ADDR_W-1:0]     window;
  logic [CFG_W-1:0]      prefix;
  logic [W_W-1:0]        words;
  logic                  finished;
  logic [P_W-1:0]        rem;
  logic [ADDR_W-1:0]     dvd;
  logic [CNT_W-1:0]      mcnt;
  logic [ADDR_W-1:0]     base;
  logic [CFG_W-1:0]      scnt;
  logic                  chk_valid;
  logic [ADDR_W-1:0]     chk_addr;
  logic [DIGIT_W-1:0]    chk_d;
  logic [DIGIT_W-1:0]    res_digit;
  logic                  res_last;
  status_t               res_status;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [EPOCH_W-1:0]    wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [EPOCH_W-1:0]    rdata;

  logic [M_W-1:0]        prod;
  logic [P_W:0]          r2;
  logic [ADDR_W-1:0]     cand;
  logic                  cfg_bad;
  logic                  err;
  logic                  unseen;
  logic                  hit;
  logic [W_W-1:0]        words_inc;
  logic                  full_inc;

  assign prod      = M_W'(state == S_POW ? p : rem) * M_W'(symbols);
  assign r2        = {rem, dvd[ADDR_W-1]};
  assign cand      = base + ADDR_W'(scnt - CFG_W'(1));
  assign cfg_bad   = (order == '0) || (symbols == '0)
                     || (5'(order) > 5'(MAX_ORDER)) || (5'(symbols) > 5'(MAX_SYMBOLS));
  assign err       = cfg_bad || sat;
  assign unseen    = rdata != cur_ep;
  assign hit       = chk_valid && unseen;
  assign words_inc = words + W_W'(1);
  assign full_inc  = P_W'(words_inc) >= p;
  assign s_tready  = state == S_IDLE;

  always_comb begin
    we    = 1'b0;
    waddr = chk_addr;
    wdata = cur_ep;
    raddr = (state == S_SEARCH) ? cand : '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_PRE: begin
        we    = unseen;
        waddr = '0;
      end
      S_SEARCH: begin
        we = hit;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  dbgg_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (STORE_WORDS)
  ) u_seen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      order     <= CFG_W'(1);
      symbols   <= CFG_W'(2);
      dirty     <= 1'b1;
      pend      <= 1'b0;
      clr_addr  <= '0;
      cur_ep    <= EPOCH_W'(1);
      p         <= P_W'(1);
      high      <= P_W'(1);
      sat       <= 1'b0;
      pcnt      <= '0;
      window    <= '0;
      prefix    <= '0;
      words     <= '0;
      finished  <= 1'b0;
      chk_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
            clr_addr <= '0;
            pend     <= 1'b0;
            state    <= pend ? S_START : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata[0]) begin
              window   <= '0;
              prefix   <= '0;
              words    <= '0;
              finished <= 1'b0;
              if (cur_ep == '1) begin
                cur_ep <= EPOCH_W'(1);
                pend   <= 1'b1;
                state  <= S_CLEAR;
              end else begin
                cur_ep <= cur_ep + EPOCH_W'(1);
                state  <= S_START;
              end
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          if (dirty) begin
            p     <= P_W'(1);
            high  <= P_W'(1);
            sat   <= 1'b0;
            pcnt  <= order;
            state <= S_POW;
          end else begin
            state <= S_EVAL;
          end
        end
        S_POW: begin
          if (pcnt == '0 || sat) begin
            if (!cfg_we) begin
              dirty <= 1'b0;
            end
            state <= S_EVAL;
          end else begin
            high <= p;
            if (prod > M_W'(STORE_WORDS)) begin
              p   <= P_W'(STORE_WORDS + 1);
              sat <= 1'b1;
            end else begin
              p <= P_W'(prod);
            end
            pcnt <= pcnt - CFG_W'(1);
          end
        end
        S_EVAL: begin
          res_digit <= '0;
          res_last  <= 1'b0;
          if (err) begin
            res_status <= ST_ERR;
            state      <= S_DONE;
          end else if (finished || P_W'(words) >= p) begin
            finished   <= 1'b1;
            res_status <= ST_FIN;
            state      <= S_DONE;
          end else if (prefix < order) begin
            res_status <= ST_OK;
            prefix     <= prefix + CFG_W'(1);
            if (prefix + CFG_W'(1) >= order) begin
              window <= '0;
              state  <= S_PRE;
            end else begin
              state <= S_DONE;
            end
          end else begin
            res_status <= ST_OK;
            rem        <= '0;
            dvd        <= window;
            mcnt       <= CNT_W'(ADDR_W);
            state      <= S_MOD;
          end
        end
        S_PRE: begin
          if (unseen) begin
            words <= words_inc;
            if (full_inc) begin
              finished <= 1'b1;
              res_last <= 1'b1;
            end
          end else if (P_W'(words) >= p) begin
            finished <= 1'b1;
            res_last <= 1'b1;
          end
          state <= S_DONE;
        end
        S_MOD: begin
          if (r2 >= {1'b0, high}) begin
            rem <= P_W'(r2 - {1'b0, high});
          end else begin
            rem <= P_W'(r2);
          end
          dvd  <= dvd << 1;
          mcnt <= mcnt - CNT_W'(1);
          if (mcnt == CNT_W'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          base      <= ADDR_W'(prod);
          scnt      <= symbols;
          chk_valid <= 1'b0;
          state     <= S_SEARCH;
        end
        S_SEARCH: begin
          if (hit) begin
            words     <= words_inc;
            window    <= chk_addr;
            res_digit <= chk_d;
            if (full_inc) begin
              finished <= 1'b1;
              res_last <= 1'b1;
            end
            chk_valid <= 1'b0;
            state     <= S_DONE;
          end else if (scnt == '0) begin
            finished   <= 1'b1;
            res_status <= ST_FIN;
            chk_valid  <= 1'b0;
            state      <= S_DONE;
          end else begin
            chk_valid <= 1'b1;
            chk_addr  <= cand;
            chk_d     <= DIGIT_W'(scnt - CFG_W'(1));
            scnt      <= scnt - CFG_W'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_W'(res_digit);
            m_tlast  <= res_last;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_addr)
          REG_ORDER:   order   <= cfg_data;
          REG_SYMBOLS: symbols <= cfg_data;
          default:     order   <= cfg_data;
        endcase
      end
    end
  end

endmodule

[src/dbgg_ram.sv]
// ----------------------------------------------------------------------------
// dbgg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbgg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dbgg_checker.sv]
// ----------------------------------------------------------------------------
// dbgg_checker
// Port-level checks of the de Bruijn generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "de_bruijn_greedy_generator_top_assert.svh"

module dbgg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [dbgg_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tlast,
  input dbgg_pkg::status_t            m_tuser
);

  import dbgg_pkg::*;

  // hold a stalled result
  `DBGG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

  // finished and error answers carry no digit and no last flag
  `DBGG_ASSERT_NOW(a_no_digit, m_tvalid && (m_tuser != ST_OK), (m_tdata == '0) && !m_tlast, "digit or last on a non-digit answer")

  // one request in flight: busy right after a transfer in
  `DBGG_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // padding bits of the digit stay zero
  `DBGG_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[TDATA_W-1:DIGIT_W] == '0, "nonzero tdata padding")

endmodule

bind de_bruijn_greedy_generator_top dbgg_checker u_dbgg_checker (.*);
